[design/mccm_pkg.sv]
// MIDI CC level mapper: shared package.
// Types, codes and defaults used by the core and its iterative unit. No dependencies.
`default_nettype none
package mccm_pkg;

    localparam int CELLS_DEF    = 64;
    localparam int CHANNELS_DEF = 16;

    localparam logic [3:0] CC_STATUS = 4'hB;

    typedef enum logic [1:0] {
        ACT_MIDI    = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_ARM     = 2'd2,
        ACT_ASSIGN  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_SMOOTH_ENABLE  = 2'd0,
        REG_MPE_MODE       = 2'd1,
        REG_LSB_MODE       = 2'd2,
        REG_SMOOTHING_STEP = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [3:0]        midi_status;
        logic [3:0]        midi_channel;
        logic [6:0]        controller;
        logic signed [7:0] cc_value;
        logic [5:0]        cell_req;
        logic [3:0]        out_channel;
        logic signed [7:0] assign_cc;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] level;
        logic               level_valid;
        logic               learned;
        logic [5:0]         learned_cell;
    } out_item_t;

    localparam int ITER_A_W   = 22;
    localparam int ITER_B_W   = 16;
    localparam int ITER_RES_W = 38;

    // x / 127 for x below 2^15 is (x * 33027) >> 22
    localparam logic [ITER_B_W-1:0] DIV127_RECIP = 16'd33027;
    localparam int                  DIV127_SHIFT = 22;

    typedef struct packed {
        logic                start;
        logic [ITER_A_W-1:0] a;
        logic [ITER_B_W-1:0] b;
    } iter_req_t;

    typedef struct packed {
        logic                  done;
        logic [ITER_RES_W-1:0] result;
    } iter_rsp_t;

endpackage
`default_nettype wire

[design/midi_cc_to_level_mapper_core.sv]
// MIDI CC level mapper: top level with sequencer, tables and result register.
// Depends on mccm_pkg and mccm_iter_unit.
//
//  channel | signals                          | handshake
//  --------+----------------------------------+------------------------------
//  in      | in_valid, in_stall, in_data      | request taken: valid & !stall
//  out     | out_valid, out_stall, out_data   | request taken: valid & !stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, | write on valid & ready
//          | cfg_data                         | (always ready)
//
// One request at a time. A learn bind adds a sweep of the cell map (one map read
// port); an assign sweeps it as well, but an unbind skips the sweep. An output
// request on a mapped cell uses the shared unit for 16-step multiplies: the
// reciprocal of 127, then the filter gain when smoothed.
// Reset: a clearing pass over all 2^(7+CH_W) value-table addresses (2048 by default)
// zeroes the value, MSB and filter tables and loads the cell map; in_stall
// stays high meanwhile. out_stall holds a finished result in the output
// register; the next request is taken meanwhile and waits at its end.
`default_nettype none
module midi_cc_to_level_mapper_core #(
    parameter int CELLS    = mccm_pkg::CELLS_DEF,
    parameter int CHANNELS = mccm_pkg::CHANNELS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  mccm_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  wire                  out_stall,
    output mccm_pkg::out_item_t  out_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [1:0]            cfg_index,
    input  wire [15:0]           cfg_data
);
    import mccm_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int VT_AW  = 7 + CH_W;
    localparam int MS_AW  = 5 + CH_W;
    localparam int FL_AW  = CELL_W + CH_W;

    typedef enum logic [15:0] {
        S_CLEAR    = 16'h0001,
        S_IDLE     = 16'h0002,
        S_CC_RD    = 16'h0004,
        S_CC_CHK   = 16'h0008,
        S_CC_WR2   = 16'h0010,
        S_SCAN_RD  = 16'h0020,
        S_SCAN_CMP = 16'h0040,
        S_BIND_WR  = 16'h0080,
        S_RQ_MAP   = 16'h0100,
        S_RQ_VAL   = 16'h0200,
        S_RQ_LSB   = 16'h0400,
        S_RQ_CV    = 16'h0800,
        S_RQ_DIV   = 16'h1000,
        S_RQ_DIFF  = 16'h2000,
        S_RQ_MUL   = 16'h4000,
        S_DONE     = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic        smooth_en_reg;
    logic        mpe_reg;
    logic        lsb_reg;
    logic [15:0] step_reg;

    // request in flight
    in_item_t              item_reg;
    logic [CH_W-1:0]       ch_reg;
    logic [CELL_W-1:0]     cell_reg;
    out_item_t             res_reg;
    logic                  learn_valid_reg;
    logic [CELL_W-1:0]     learn_cell_reg;
    logic [CELL_W-1:0]     bind_cell_reg;
    logic [7:0]            bind_val_reg;
    logic [CELL_W-1:0]     scan_reg;
    logic [VT_AW-1:0]      clr_reg;
    logic [7:0]            msbq_hold_reg;
    logic [6:0]            rq_cc_reg;
    logic signed [7:0]     msb_v_reg;
    logic signed [23:0]    f_reg;
    logic [13:0]           cv_abs_reg;
    logic                  cv_neg_reg;
    logic signed [23:0]    target_reg;
    logic                  diff_neg_reg;

    // output register
    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    // memories
    logic signed [7:0]  value_mem [0:(1<<VT_AW)-1];
    logic signed [7:0]  msb_mem   [0:(1<<MS_AW)-1];
    logic signed [23:0] filt_mem  [0:(1<<FL_AW)-1];
    logic [7:0]         map_mem   [0:(1<<CELL_W)-1];

    logic               vt_we;
    logic [VT_AW-1:0]   vt_wa, vt_ra;
    logic signed [7:0]  vt_wd;
    logic signed [7:0]  vt_q_reg;
    logic               ms_we;
    logic [MS_AW-1:0]   ms_a;
    logic signed [7:0]  ms_wd;
    logic signed [7:0]  ms_q_reg;
    logic               fl_we;
    logic [FL_AW-1:0]   fl_a;
    logic signed [23:0] fl_wd;
    logic signed [23:0] fl_q_reg;
    logic               map_we;
    logic [CELL_W-1:0]  map_wa, map_ra;
    logic [7:0]         map_wd;
    logic [7:0]         map_q_reg;

    iter_req_t iter_req;
    iter_rsp_t iter_rsp;

    mccm_iter_unit u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iter_req),
        .rsp   (iter_rsp)
    );

    // ---------------- decode at the accepting edge ----------------
    logic              in_take;
    logic [3:0]        mch_eff;
    logic              mch_ok, och_ok, cell_ok;
    logic              cc_lsb_pair;     // controller 32..63 in 14-bit mode
    logic              cc_msb_part;     // controller 0..31 in 14-bit mode
    logic              hit;

    assign in_take  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        mch_eff = mpe_reg ? in_data.midi_channel : 4'd0;
        mch_ok  = ({1'b0, mch_eff} < 5'(CHANNELS));
        och_ok  = mpe_reg ? ({1'b0, in_data.out_channel} < 5'(CHANNELS))
                          : (in_data.out_channel == 4'd0);
        cell_ok = ({2'b00, in_data.cell_req} < 8'(CELLS));
    end

    assign cc_msb_part = lsb_reg && (item_reg.controller[6:5] == 2'b00);
    assign cc_lsb_pair = lsb_reg && (item_reg.controller[6:5] == 2'b01);
    assign hit         = learn_valid_reg && (vt_q_reg != item_reg.cc_value);

    // ---------------- request arithmetic ----------------
    logic signed [15:0] cv_raw, cv_clamp;
    logic [15:0]        cv_abs16;
    logic [22:0]        tgt_mag;
    logic signed [24:0] diff;
    logic [24:0]        diff_abs;
    logic               diff_small;
    logic [ITER_RES_W-1:0] prod_rnd;
    logic [22:0]        step_mag;
    logic signed [24:0] f_new;

    always_comb
    begin
        cv_raw = 16'(msb_v_reg) * 16'sd128;
        if (rq_cc_reg[6:5] == 2'b00 && lsb_reg)
            cv_raw = cv_raw + 16'(vt_q_reg);
        if (cv_raw > 16'sd16256)
            cv_clamp = 16'sd16256;
        else if (cv_raw < -16'sd16256)
            cv_clamp = -16'sd16256;
        else
            cv_clamp = cv_raw;
        cv_abs16 = cv_clamp[15] ? 16'(-cv_clamp) : 16'(cv_clamp);

        // |cv|*32768/127 = 258*|cv| + (2*|cv| + 63)/127, rounded half away;
        // the quotient comes from the reciprocal product in the shared unit
        tgt_mag = 23'({cv_abs_reg, 8'b0}) + 23'({cv_abs_reg, 1'b0})
                + 23'(iter_rsp.result[DIV127_SHIFT+8:DIV127_SHIFT]);

        diff       = 25'(target_reg) - 25'(f_reg);
        diff_abs   = diff[24] ? 25'(-diff) : 25'(diff);
        diff_small = (diff > -25'sd4194304) && (diff < 25'sd4194304);

        prod_rnd = iter_rsp.result + ITER_RES_W'(32768);
        step_mag = 23'(prod_rnd[ITER_RES_W-1:16]);
        f_new    = diff_neg_reg ? (25'(f_reg) - 25'(step_mag))
                                : (25'(f_reg) + 25'(step_mag));
    end

    // ---------------- sequencer and memory control ----------------
    always_comb
    begin
        state_next = state_reg;
        vt_we  = 1'b0;
        vt_wa  = {item_reg.controller, ch_reg};
        vt_wd  = item_reg.cc_value;
        vt_ra  = {item_reg.controller, ch_reg};
        ms_we  = 1'b0;
        ms_a   = {item_reg.controller[4:0], ch_reg};
        ms_wd  = item_reg.cc_value;
        fl_we  = 1'b0;
        fl_a   = {cell_reg, ch_reg};
        fl_wd  = target_reg;
        map_we = 1'b0;
        map_wa = bind_cell_reg;
        map_wd = bind_val_reg;
        map_ra = cell_reg;
        iter_req.start = 1'b0;
        iter_req.a     = '0;
        iter_req.b     = '0;

        case (state_reg)
            S_CLEAR:
            begin
                vt_we  = 1'b1;
                vt_wa  = clr_reg;
                vt_wd  = '0;
                ms_we  = 1'b1;
                ms_a   = {clr_reg[CH_W+4:CH_W], clr_reg[CH_W-1:0]};
                ms_wd  = '0;
                fl_we  = 1'b1;
                fl_a   = {clr_reg[CH_W+CELL_W-1:CH_W], clr_reg[CH_W-1:0]};
                fl_wd  = '0;
                map_we = 1'b1;
                map_wa = clr_reg[CH_W+CELL_W-1:CH_W];
                map_wd = {1'b0, 7'(clr_reg[CH_W+CELL_W-1:CH_W])};
                if (&clr_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    case (in_data.action)
                        ACT_MIDI:
                            state_next = (in_data.midi_status == CC_STATUS && mch_ok)
                                         ? S_CC_RD : S_DONE;
                        ACT_REQUEST:
                            state_next = (cell_ok && och_ok) ? S_RQ_MAP : S_DONE;
                        ACT_ASSIGN:
                            if (!cell_ok)
                                state_next = S_DONE;
                            else if (in_data.assign_cc[7])
                                state_next = S_BIND_WR;
                            else
                                state_next = S_SCAN_RD;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_CC_RD:
                state_next = S_CC_CHK;
            S_CC_CHK:
            begin
                // learn looks at the stored value before this message lands
                if (cc_msb_part)
                    ms_we = 1'b1;
                else
                    vt_we = 1'b1;
                if (cc_lsb_pair)
                    state_next = S_CC_WR2;
                else
                    state_next = hit ? S_SCAN_RD : S_DONE;
            end
            S_CC_WR2:
            begin
                vt_we = 1'b1;
                vt_wa = {2'b00, item_reg.controller[4:0], ch_reg};
                vt_wd = msbq_hold_reg;
                state_next = res_reg.learned ? S_SCAN_RD : S_DONE;
            end
            S_SCAN_RD:
            begin
                map_ra = scan_reg;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (map_q_reg == bind_val_reg)
                begin
                    map_we = 1'b1;
                    map_wa = scan_reg;
                    map_wd = 8'hFF;
                end
                state_next = (scan_reg == CELL_W'(CELLS - 1)) ? S_BIND_WR : S_SCAN_RD;
            end
            S_BIND_WR:
            begin
                map_we = 1'b1;
                state_next = S_DONE;
            end
            S_RQ_MAP:
                state_next = S_RQ_VAL;
            S_RQ_VAL:
            begin
                vt_ra = {map_q_reg[6:0], ch_reg};
                state_next = map_q_reg[7] ? S_DONE : S_RQ_LSB;
            end
            S_RQ_LSB:
            begin
                vt_ra = {2'b01, rq_cc_reg[4:0], ch_reg};
                state_next = S_RQ_CV;
            end
            S_RQ_CV:
            begin
                // (2*|cv| + 63) / 127 by reciprocal multiply
                iter_req.start = 1'b1;
                iter_req.a     = ITER_A_W'({cv_abs16[13:0], 1'b0}) + ITER_A_W'(63);
                iter_req.b     = DIV127_RECIP;
                state_next = S_RQ_DIV;
            end
            S_RQ_DIV:
                if (iter_rsp.done)
                    state_next = S_RQ_DIFF;
            S_RQ_DIFF:
            begin
                if (smooth_en_reg && diff_small)
                begin
                    iter_req.start = 1'b1;
                    iter_req.a     = diff_abs[ITER_A_W-1:0];
                    iter_req.b     = step_reg;
                    state_next = S_RQ_MUL;
                end
                else
                begin
                    fl_we = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_RQ_MUL:
            begin
                if (iter_rsp.done)
                begin
                    fl_we = 1'b1;
                    fl_wd = f_new[23:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_CLEAR;
        endcase
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (vt_we)
            value_mem[vt_wa] <= vt_wd;
        vt_q_reg <= value_mem[vt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ms_we)
            msb_mem[ms_a] <= ms_wd;
        ms_q_reg <= msb_mem[ms_a];
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
            filt_mem[fl_a] <= fl_wd;
        fl_q_reg <= filt_mem[fl_a];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        map_q_reg <= map_mem[map_ra];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            smooth_en_reg   <= 1'b1;
            mpe_reg         <= 1'b0;
            lsb_reg         <= 1'b0;
            step_reg        <= 16'd45;
            learn_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + VT_AW'(1);

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SMOOTH_ENABLE:  smooth_en_reg <= cfg_data[0];
                    REG_MPE_MODE:       mpe_reg       <= cfg_data[0];
                    REG_LSB_MODE:       lsb_reg       <= cfg_data[0];
                    REG_SMOOTHING_STEP: step_reg      <= cfg_data;
                    default:            ;
                endcase
            end

            // arm replaces any earlier target; a learn hit drops it
            if (in_take && in_data.action == ACT_ARM && cell_ok)
                learn_valid_reg <= 1'b1;
            else if (state_reg == S_CC_CHK && hit)
                learn_valid_reg <= 1'b0;

            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
            ch_reg   <= (in_data.action == ACT_REQUEST) ? CH_W'(in_data.out_channel)
                                                        : CH_W'(mch_eff);
            cell_reg <= CELL_W'(in_data.cell_req);
            res_reg  <= '0;
            scan_reg <= '0;
            if (in_data.action == ACT_ARM && cell_ok)
                learn_cell_reg <= CELL_W'(in_data.cell_req);
            bind_cell_reg <= CELL_W'(in_data.cell_req);
            bind_val_reg  <= in_data.assign_cc[7] ? 8'hFF : {1'b0, in_data.assign_cc[6:0]};
        end

        case (state_reg)
            S_CC_CHK:
            begin
                msbq_hold_reg <= ms_q_reg;
                if (hit)
                begin
                    res_reg.learned      <= 1'b1;
                    res_reg.learned_cell <= 6'(learn_cell_reg);
                    bind_cell_reg        <= learn_cell_reg;
                    bind_val_reg         <= {1'b0, item_reg.controller};
                end
            end
            S_SCAN_CMP:
                scan_reg <= scan_reg + CELL_W'(1);
            S_RQ_VAL:
            begin
                res_reg.level_valid <= 1'b1;
                rq_cc_reg <= map_q_reg[6:0];
            end
            S_RQ_LSB:
            begin
                msb_v_reg <= vt_q_reg;
                f_reg     <= fl_q_reg;
            end
            S_RQ_CV:
            begin
                cv_abs_reg <= cv_abs16[13:0];
                cv_neg_reg <= cv_clamp[15];
            end
            S_RQ_DIV:
                if (iter_rsp.done)
                    target_reg <= cv_neg_reg ? -24'(tgt_mag) : 24'(tgt_mag);
            S_RQ_DIFF:
            begin
                diff_neg_reg <= diff[24];
                if (!(smooth_en_reg && diff_small))
                    res_reg.level <= target_reg;
            end
            S_RQ_MUL:
                if (iter_rsp.done)
                    res_reg.level <= f_new[23:0];
            default:
                ;
        endcase

        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
            out_data_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

[design/mccm_iter_unit.sv]
// MIDI CC level mapper: shared shift-and-add unit.
// Unsigned multiply (a * b), one bit of b a cycle. Uses mccm_pkg.
`default_nettype none
module mccm_iter_unit (
    input  wire                  clk,
    input  wire                  rst_n,
    input  mccm_pkg::iter_req_t  req,
    output mccm_pkg::iter_rsp_t  rsp
);
    import mccm_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [3:0]            cnt_reg;
    logic [ITER_A_W-1:0]   opa_reg;
    logic [ITER_B_W-1:0]   opb_reg;
    logic [ITER_RES_W-1:0] acc_reg;

    logic [ITER_RES_W-1:0] addend;
    logic [ITER_RES_W-1:0] sum;

    // Take b from the top bit down: shift the sum and add a where the bit is set
    always_comb
    begin
        addend = opb_reg[ITER_B_W-1] ? ITER_RES_W'(opa_reg) : '0;
        sum    = {acc_reg[ITER_RES_W-2:0], 1'b0} + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (&cnt_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            opa_reg <= req.a;
            opb_reg <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum;
            opb_reg <= {opb_reg[ITER_B_W-2:0], 1'b0};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for midi_cc_to_level_mapper_core: directed and random CC, request, learn and
// assign traffic under several register settings, each result checked against an in-bench
// predictor. Depends on mccm_pkg and the core RTL.
`timescale 1ns / 100ps
module tb;
    import mccm_pkg::*;

    localparam int FULL_SCALE  = 4194304;
    localparam int CLAMP_LIMIT = 16256;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IN_W        = $bits(in_item_t);

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    midi_cc_to_level_mapper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block state, kept in plain ints for easy arithmetic.
    int cc_values [128][16];
    int msb_store [32][16];
    int cell_cc   [64];
    int armed_cell;
    int filt_level [64][16];
    bit smooth_on;
    bit mpe_on;
    bit pair_on;
    int unsigned filt_gain;

    out_item_t expected_levels[$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        requests_sent = 0;
    int        learns_seen = 0;
    longint    cycles = 0;
    bit        calm = 1'b0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_levels.size());
            $display("FAIL midi_cc_to_level_mapper_core");
            $finish;
        end
    end

    // Receiver back-pressure; none while the calm stretch runs.
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 26);

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s at cycle %0d: got %0d, want %0d", what, cycles, got, want);
        mismatches++;
    endtask

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_levels.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_levels.pop_front();
                if (out_data.level !== want.level)
                    report_mismatch("level", out_data.level, want.level);
                if (out_data.level_valid !== want.level_valid)
                    report_mismatch("level_valid", out_data.level_valid, want.level_valid);
                if (out_data.learned !== want.learned)
                    report_mismatch("learned", out_data.learned, want.learned);
                if (out_data.learned_cell !== want.learned_cell)
                    report_mismatch("learned_cell", out_data.learned_cell, want.learned_cell);
                if (out_data.learned)
                    learns_seen++;
            end
        end
    end

    function automatic longint round_div(longint n, longint d);
        longint m, q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    task automatic clear_model();
        foreach (cc_values[i, j]) cc_values[i][j] = 0;
        foreach (msb_store[i, j]) msb_store[i][j] = 0;
        foreach (filt_level[i, j]) filt_level[i][j] = 0;
        foreach (cell_cc[i]) cell_cc[i] = i;
        armed_cell = -1;
        smooth_on = 1'b1;
        mpe_on = 1'b0;
        pair_on = 1'b0;
        filt_gain = 45;
    endtask

    // Binding a controller unmaps any other cell that held it.
    task automatic bind_controller(int tgt_cell, int cc);
        if (cc >= 0)
            foreach (cell_cc[i])
                if (cell_cc[i] == cc)
                    cell_cc[i] = -1;
        cell_cc[tgt_cell] = (cc < 0) ? -1 : cc;
    endtask

    task automatic predict_level(input in_item_t it, output out_item_t res);
        int ch, cc, val, cell_idx, cv, tgt, dif;
        res = '0;
        cell_idx = int'(it.cell_req);
        case (action_t'(it.action))
            ACT_MIDI:
            begin
                if (it.midi_status == CC_STATUS)
                begin
                    ch = mpe_on ? int'(it.midi_channel) : 0;
                    cc = int'(it.controller);
                    val = int'(it.cc_value);
                    if (armed_cell >= 0 && cc_values[cc][ch] != val)
                    begin
                        res.learned = 1'b1;
                        res.learned_cell = 6'(armed_cell);
                        bind_controller(armed_cell, cc);
                        armed_cell = -1;
                    end
                    if (pair_on && cc < 32)
                        msb_store[cc][ch] = val;
                    else if (pair_on && cc < 64)
                    begin
                        cc_values[cc - 32][ch] = msb_store[cc - 32][ch];
                        cc_values[cc][ch] = val;
                    end
                    else
                        cc_values[cc][ch] = val;
                end
            end
            ACT_REQUEST:
            begin
                ch = int'(it.out_channel);
                if (mpe_on || ch == 0)
                begin
                    res.level_valid = 1'b1;
                    cc = cell_cc[cell_idx];
                    if (cc >= 0)
                    begin
                        cv = cc_values[cc][ch] * 128;
                        if (pair_on && cc < 32)
                            cv += cc_values[cc + 32][ch];
                        if (cv > CLAMP_LIMIT) cv = CLAMP_LIMIT;
                        if (cv < -CLAMP_LIMIT) cv = -CLAMP_LIMIT;
                        tgt = int'(round_div(longint'(cv) * 32768, 127));
                        dif = tgt - filt_level[cell_idx][ch];
                        if (smooth_on && dif < FULL_SCALE && dif > -FULL_SCALE)
                            filt_level[cell_idx][ch] += int'(round_div(
                                longint'(dif) * longint'(filt_gain), 65536));
                        else
                            filt_level[cell_idx][ch] = tgt;
                        res.level = 24'(filt_level[cell_idx][ch]);
                    end
                end
            end
            ACT_ARM:
                armed_cell = cell_idx;
            default:
                bind_controller(cell_idx, int'(it.assign_cc));
        endcase
    endtask

    // Send one request; called and returns at a falling edge, valid left high.
    task automatic send_request(input in_item_t it);
        out_item_t res;
        while (!calm && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_level(it, res);
        expected_levels.push_back(res);
        requests_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_levels.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, int unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[15:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SMOOTH_ENABLE:  smooth_on = v[0];
            REG_MPE_MODE:       mpe_on = v[0];
            REG_LSB_MODE:       pair_on = v[0];
            REG_SMOOTHING_STEP: filt_gain = v[15:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_mode(bit sm, bit mpe, bit lsb, int unsigned gain);
        drain();
        write_reg(REG_SMOOTH_ENABLE, sm);
        write_reg(REG_MPE_MODE, mpe);
        write_reg(REG_LSB_MODE, lsb);
        write_reg(REG_SMOOTHING_STEP, gain);
    endtask

    function automatic in_item_t make_item(action_t act);
        in_item_t it;
        it = in_item_t'(IN_W'({$urandom, $urandom}));
        it.action = act;
        return it;
    endfunction

    function automatic in_item_t cc_msg(int cc, int val, int ch);
        in_item_t it;
        it = make_item(ACT_MIDI);
        it.midi_status = CC_STATUS;
        it.controller = 7'(cc);
        it.cc_value = 8'(val);
        it.midi_channel = 4'(ch);
        return it;
    endfunction

    function automatic in_item_t level_req(int cell_idx, int ch);
        in_item_t it;
        it = make_item(ACT_REQUEST);
        it.cell_req = 6'(cell_idx);
        it.out_channel = 4'(ch);
        return it;
    endfunction

    function automatic in_item_t arm_req(int cell_idx);
        in_item_t it;
        it = make_item(ACT_ARM);
        it.cell_req = 6'(cell_idx);
        return it;
    endfunction

    function automatic in_item_t assign_req(int cell_idx, int cc);
        in_item_t it;
        it = make_item(ACT_ASSIGN);
        it.cell_req = 6'(cell_idx);
        it.assign_cc = 8'(cc);
        return it;
    endfunction

    // Extremes, non-CC status, learn with and without a change, rebinding and unmapping.
    task automatic test_directed();
        in_item_t it;
        send_request(cc_msg(0, 127, 0));
        send_request(level_req(0, 0));        // full-scale step jumps
        send_request(cc_msg(1, -128, 0));
        send_request(level_req(1, 0));        // clamped negative
        send_request(cc_msg(2, 3, 0));
        send_request(level_req(2, 0));        // small step is smoothed
        send_request(level_req(2, 15));       // channel not active
        it = cc_msg(3, 99, 0);
        it.midi_status = 4'h9;
        send_request(it);                     // note message ignored
        send_request(level_req(3, 0));
        send_request(arm_req(10));
        send_request(arm_req(63));            // re-arm replaces cell
        send_request(cc_msg(0, 127, 0));      // same value, no learn
        send_request(cc_msg(127, 5, 0));      // learn cell 63
        send_request(level_req(63, 0));
        send_request(assign_req(5, 0));       // steals controller 0 from cell 0
        send_request(level_req(0, 0));        // unmapped cell
        send_request(level_req(5, 0));
        send_request(assign_req(5, -1));
        send_request(assign_req(6, -128));
        send_request(level_req(6, 0));
        send_request(assign_req(7, 127));     // steals from cell 63
        send_request(level_req(63, 0));
        send_request(level_req(7, 0));
    endtask

    // Mostly well-formed traffic on a narrow set of controllers, plus noise.
    task automatic test_random(int n);
        in_item_t it;
        int r, cc;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 42)
            begin
                cc = ($urandom_range(3) != 0) ? $urandom_range(63) : $urandom_range(127);
                if (pair_on && cc < 32 && $urandom_range(1))
                begin
                    send_request(cc_msg(cc, $urandom, $urandom));
                    it = cc_msg(cc + 32, $urandom, $urandom);
                end
                else
                    it = cc_msg(cc, $urandom, $urandom);
                if ($urandom_range(9) == 0)
                    it.midi_status = 4'($urandom);
            end
            else if (r < 80)
            begin
                it = level_req($urandom_range(63), $urandom);
                if (!mpe_on && $urandom_range(4) != 0)
                    it.out_channel = 4'd0;
            end
            else if (r < 88)
                it = arm_req($urandom_range(63));
            else
            begin
                it = assign_req($urandom_range(63), $urandom_range(127));
                if ($urandom_range(4) == 0)
                    it.assign_cc = 8'(-int'($urandom_range(1, 128)));
            end
            send_request(it);
        end
    endtask

    initial
    begin
        clear_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        set_mode(1'b1, 1'b0, 1'b0, 45);
        test_random(200);
        set_mode(1'b1, 1'b1, 1'b1, 65535);
        test_random(220);
        set_mode(1'b0, 1'b1, 1'b0, 0);
        calm = 1'b1;
        test_random(200);
        calm = 1'b0;
        set_mode(1'b1, 1'b0, 1'b1, 1);
        test_random(220);
        set_mode(1'b1, 1'b1, 1'b0, $urandom_range(65535));
        test_random(220);
        drain();
        repeat (60) @(posedge clk);
        $display("sent %0d requests over five register settings; %0d results, %0d learns",
                 requests_sent, results_seen, learns_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("PASS midi_cc_to_level_mapper_core");
        else
            $display("FAIL midi_cc_to_level_mapper_core");
        $finish;
    end
endmodule

[midi_cc_to_level_mapper_core.f]
design/mccm_pkg.sv
design/mccm_iter_unit.sv
design/midi_cc_to_level_mapper_core.sv
test/tb.sv
